@@ hdl/jmss_pkg.sv @@
// Shared types and constants for the JPEG metadata segment stripper.
// Holds the parser phase enum, the result record and the marker codes.
// No dependencies.
package jmss_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SIG0    = 4'd0,
        PH_SIG1    = 4'd1,
        PH_HDR     = 4'd2,
        PH_MARK    = 4'd3,
        PH_LENHI   = 4'd4,
        PH_LENLO   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_SCAN    = 4'd7,
        PH_DONE    = 4'd8,
        PH_FAIL    = 4'd9
    } phase_t;

    // One output result
    typedef struct packed {
        logic       last;
        logic       valid;
        logic [7:0] data;
    } result_t;

    localparam int MAX_RESULTS = 4;

    // Marker codes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_STUFF  = 8'h00;
    localparam logic [7:0] MK_APP1   = 8'hE1;
    localparam logic [7:0] MK_APP2   = 8'hE2;
    localparam logic [7:0] MK_APP13  = 8'hED;

    // Data result, not final
    function automatic result_t make_res(input logic [7:0] data);
        result_t r;
        r.last  = 1'b0;
        r.valid = 1'b1;
        r.data  = data;
        return r;
    endfunction

    // Segments removed from the stream
    function automatic logic is_stripped(input logic [7:0] code);
        return (code == MK_APP1) || (code == MK_APP2) || (code == MK_APP13);
    endfunction

endpackage

@@ hdl/jpeg_metadata_segment_stripper_unit.sv @@
// Top level of the JPEG metadata segment stripper: byte parser and result burst buffer.
// Depends on jmss_pkg.
//
// Streaming JPEG metadata filter. Each input transfer carries one file byte
// (s_tdata) and an end-of-file flag (s_tlast). Files that do not start with
// FF D8 produce a single closing result (m_tuser = 0, m_tlast = 1) at end of
// file. APP1, APP2 and APP13 segments are removed; all other segments, the
// standalone markers and the entropy-coded data after SOS are copied, and
// FF D9 ends the output of a file with m_tlast set. Each input byte is parsed
// in the cycle it is accepted and yields 0 to 4 results, which are loaded into
// a four-entry burst buffer that drains one result per cycle while m_tready
// is high. Bytes that yield at most one result do not hold the input, so
// payload and scan data stream at one byte per clock while m_tready is high;
// a marker header that is kept (FF, code, two length bytes) is emitted as a
// four-result burst on its low length byte, and SOI, EOI, RST and stuffed
// markers as a two-result burst; the input is held until the last result of
// a burst leaves. There is no reset sweep; the block is ready right after reset.
module jpeg_metadata_segment_stripper_unit (
    input  logic       clk,
    input  logic       rst_n,
    // input byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_file
    // filtered output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] byte_valid
    output logic       m_tlast    // last
);

    jmss_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        marker_code_reg, marker_code_next;
    logic [7:0]        length_high_reg, length_high_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    logic              dropping_reg, dropping_next;
    logic              scan_follows_reg, scan_follows_next;
    logic              prev_was_ff_reg, prev_was_ff_next;

    jmss_pkg::result_t buf_reg [jmss_pkg::MAX_RESULTS];
    jmss_pkg::result_t res     [jmss_pkg::MAX_RESULTS];
    logic [2:0]        cnt_reg, cnt_next;
    logic [2:0]        n_res;
    logic [15:0]       seg_len;
    logic              accept;
    logic              pop;
    logic              drop_seg;
    logic              standalone;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    // take a new byte once the buffer is empty or its last result leaves now
    assign s_tready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = buf_reg[0].data;
    assign m_tuser  = buf_reg[0].valid;
    assign m_tlast  = buf_reg[0].last;

    assign seg_len    = {length_high_reg, s_tdata};
    assign drop_seg   = jmss_pkg::is_stripped(marker_code_reg);
    assign standalone = (s_tdata == jmss_pkg::MK_SOI) || (s_tdata == jmss_pkg::MK_STUFF) ||
                        ((s_tdata >= jmss_pkg::MK_RST0) && (s_tdata <= jmss_pkg::MK_RST7));

    // Parser next state for the byte at the input
    always_comb
    begin
        phase_next        = phase_reg;
        marker_code_next  = marker_code_reg;
        length_high_next  = length_high_reg;
        bytes_left_next   = bytes_left_reg;
        dropping_next     = dropping_reg;
        scan_follows_next = scan_follows_reg;
        prev_was_ff_next  = prev_was_ff_reg;

        unique case (phase_reg)
            jmss_pkg::PH_SIG0:
            begin
                phase_next = (s_tdata == jmss_pkg::MK_PREFIX) ? jmss_pkg::PH_SIG1
                                                              : jmss_pkg::PH_FAIL;
            end
            jmss_pkg::PH_SIG1:
            begin
                phase_next = (s_tdata == jmss_pkg::MK_SOI) ? jmss_pkg::PH_HDR
                                                           : jmss_pkg::PH_FAIL;
            end
            jmss_pkg::PH_HDR:
            begin
                if (!s_tlast && (s_tdata == jmss_pkg::MK_PREFIX))
                begin
                    phase_next = jmss_pkg::PH_MARK;
                end
            end
            jmss_pkg::PH_MARK:
            begin
                if (s_tdata == jmss_pkg::MK_EOI)
                begin
                    phase_next = jmss_pkg::PH_DONE;
                end
                else if (standalone)
                begin
                    phase_next = jmss_pkg::PH_HDR;
                end
                else
                begin
                    marker_code_next = s_tdata;
                    phase_next       = jmss_pkg::PH_LENHI;
                end
            end
            jmss_pkg::PH_LENHI:
            begin
                length_high_next = s_tdata;
                phase_next       = jmss_pkg::PH_LENLO;
            end
            jmss_pkg::PH_LENLO:
            begin
                // length below 2: marker and length bytes vanish
                if (seg_len < 16'd2)
                begin
                    phase_next = jmss_pkg::PH_HDR;
                end
                else
                begin
                    dropping_next     = drop_seg;
                    scan_follows_next = !drop_seg && (marker_code_reg == jmss_pkg::MK_SOS);
                    bytes_left_next   = seg_len - 16'd2;
                    if (seg_len == 16'd2)
                    begin
                        phase_next = scan_follows_next ? jmss_pkg::PH_SCAN : jmss_pkg::PH_HDR;
                        prev_was_ff_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = jmss_pkg::PH_PAYLOAD;
                    end
                end
            end
            jmss_pkg::PH_PAYLOAD:
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1)
                begin
                    phase_next = scan_follows_reg ? jmss_pkg::PH_SCAN : jmss_pkg::PH_HDR;
                    prev_was_ff_next = 1'b0;
                end
            end
            jmss_pkg::PH_SCAN:
            begin
                if (prev_was_ff_reg && (s_tdata == jmss_pkg::MK_EOI))
                begin
                    phase_next = jmss_pkg::PH_DONE;
                end
                prev_was_ff_next = (s_tdata == jmss_pkg::MK_PREFIX);
            end
            jmss_pkg::PH_DONE:
            begin
                phase_next = jmss_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = jmss_pkg::PH_FAIL;
            end
        endcase

        // end of file: rearm for the next file
        if (s_tlast)
        begin
            phase_next        = jmss_pkg::PH_SIG0;
            marker_code_next  = 8'h00;
            length_high_next  = 8'h00;
            bytes_left_next   = 16'h0000;
            dropping_next     = 1'b0;
            scan_follows_next = 1'b0;
            prev_was_ff_next  = 1'b0;
        end
    end

    // Parser results for the byte at the input
    always_comb
    begin
        n_res = 3'd0;
        for (int i = 0; i < jmss_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        unique case (phase_reg)
            jmss_pkg::PH_SIG1:
            begin
                if (s_tdata == jmss_pkg::MK_SOI)
                begin
                    res[0] = jmss_pkg::make_res(jmss_pkg::MK_PREFIX);
                    res[1] = jmss_pkg::make_res(jmss_pkg::MK_SOI);
                    n_res  = 3'd2;
                end
            end
            jmss_pkg::PH_HDR:
            begin
                // a trailing header byte is dropped
                if (!s_tlast && (s_tdata != jmss_pkg::MK_PREFIX))
                begin
                    res[0] = jmss_pkg::make_res(s_tdata);
                    n_res  = 3'd1;
                end
            end
            jmss_pkg::PH_MARK:
            begin
                if (s_tdata == jmss_pkg::MK_EOI)
                begin
                    res[0]      = jmss_pkg::make_res(jmss_pkg::MK_PREFIX);
                    res[1]      = jmss_pkg::make_res(jmss_pkg::MK_EOI);
                    res[1].last = 1'b1;
                    n_res       = 3'd2;
                end
                else if (standalone)
                begin
                    res[0] = jmss_pkg::make_res(jmss_pkg::MK_PREFIX);
                    res[1] = jmss_pkg::make_res(s_tdata);
                    n_res  = 3'd2;
                end
            end
            jmss_pkg::PH_LENLO:
            begin
                if ((seg_len >= 16'd2) && !drop_seg)
                begin
                    res[0] = jmss_pkg::make_res(jmss_pkg::MK_PREFIX);
                    res[1] = jmss_pkg::make_res(marker_code_reg);
                    res[2] = jmss_pkg::make_res(length_high_reg);
                    res[3] = jmss_pkg::make_res(s_tdata);
                    n_res  = 3'd4;
                end
            end
            jmss_pkg::PH_PAYLOAD:
            begin
                if (!dropping_reg)
                begin
                    res[0] = jmss_pkg::make_res(s_tdata);
                    n_res  = 3'd1;
                end
            end
            jmss_pkg::PH_SCAN:
            begin
                res[0] = jmss_pkg::make_res(s_tdata);
                n_res  = 3'd1;
                if (prev_was_ff_reg && (s_tdata == jmss_pkg::MK_EOI))
                begin
                    res[0].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // end of file: flag the final result or add a closing one
        if (s_tlast && (phase_reg != jmss_pkg::PH_DONE))
        begin
            if (n_res == 3'd0)
            begin
                res[0].data  = 8'h00;
                res[0].valid = 1'b0;
                res[0].last  = 1'b1;
                n_res        = 3'd1;
            end
            else
            begin
                for (int i = 0; i < jmss_pkg::MAX_RESULTS; i++)
                begin
                    if (3'(i) == (n_res - 3'd1))
                    begin
                        res[i].last = 1'b1;
                    end
                end
            end
        end
    end

    // Buffer fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = n_res;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    // Parser state and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= jmss_pkg::PH_SIG0;
            marker_code_reg  <= 8'h00;
            length_high_reg  <= 8'h00;
            bytes_left_reg   <= 16'h0000;
            dropping_reg     <= 1'b0;
            scan_follows_reg <= 1'b0;
            prev_was_ff_reg  <= 1'b0;
            cnt_reg          <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                phase_reg        <= phase_next;
                marker_code_reg  <= marker_code_next;
                length_high_reg  <= length_high_next;
                bytes_left_reg   <= bytes_left_next;
                dropping_reg     <= dropping_next;
                scan_follows_reg <= scan_follows_next;
                prev_was_ff_reg  <= prev_was_ff_next;
            end
        end
    end

    // Result burst: load on accept, shift toward the head on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < jmss_pkg::MAX_RESULTS; i++)
            begin
                buf_reg[i] <= res[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < jmss_pkg::MAX_RESULTS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("burst count out of range");

    a_closing_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == 8'h00)))
        else $error("empty result is not a closing result");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == jmss_pkg::PH_PAYLOAD) |-> (bytes_left_reg != 16'h0000))
        else $error("payload phase with nothing left");

    a_done_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg != jmss_pkg::PH_DONE) && (phase_next == jmss_pkg::PH_DONE))
        |=> (m_tvalid && (cnt_reg != 3'd0)))
        else $error("end of image without buffered result");

endmodule

@@ dv/jpeg_metadata_segment_stripper_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for jpeg_metadata_segment_stripper_unit: directed marker cases, random
// files under several idle/stall mixes, and a long output hold-off.
// Depends on jmss_pkg and the stripper RTL; checks results against its own parser model.
module jpeg_metadata_segment_stripper_unit_tb;

    localparam int          HOLD_CYCLES = 200;
    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 16;
    localparam logic [7:0]  MK_SOF0     = 8'hC0;
    localparam logic [7:0]  MK_DHT      = 8'hC4;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // Parser model state
    jmss_pkg::phase_t parse_phase;
    logic [7:0]  seg_code;
    logic [7:0]  seg_len_hi;
    logic [15:0] seg_left;
    logic        seg_dropped;
    logic        scan_after_seg;
    logic        scan_prev_ff;

    jmss_pkg::result_t pending_out[$];
    jmss_pkg::result_t want_res;
    logic [7:0]  file_bytes[$];
    int          fail_cnt       = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    int          hold_reqs      = 0;
    int          hold_grants    = 0;

    jpeg_metadata_segment_stripper_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    //--------------------------------------------------------------------------
    // Parser model
    //--------------------------------------------------------------------------
    function automatic void reset_parser();
        parse_phase    = jmss_pkg::PH_SIG0;
        seg_code       = 8'h00;
        seg_len_hi     = 8'h00;
        seg_left       = 16'h0000;
        seg_dropped    = 1'b0;
        scan_after_seg = 1'b0;
        scan_prev_ff   = 1'b0;
    endfunction

    function automatic void push_out(input logic [7:0] data, input logic valid,
                                     input logic fin);
        jmss_pkg::result_t r;
        r.data  = data;
        r.valid = valid;
        r.last  = fin;
        pending_out = {pending_out, r};
    endfunction

    function automatic void close_segment();
        parse_phase  = scan_after_seg ? jmss_pkg::PH_SCAN : jmss_pkg::PH_HDR;
        scan_prev_ff = 1'b0;
    endfunction

    // Work out the filtered bytes caused by one accepted file byte
    task automatic predict_filtered(input logic [7:0] b, input logic eof);
        jmss_pkg::phase_t entry;
        logic [15:0] seg_len;
        int          start;
        entry = parse_phase;
        start = pending_out.size();
        case (parse_phase)
            jmss_pkg::PH_SIG0:
                parse_phase = (b == jmss_pkg::MK_PREFIX) ? jmss_pkg::PH_SIG1
                                                         : jmss_pkg::PH_FAIL;
            jmss_pkg::PH_SIG1:
            begin
                if (b == jmss_pkg::MK_SOI)
                begin
                    push_out(jmss_pkg::MK_PREFIX, 1'b1, 1'b0);
                    push_out(jmss_pkg::MK_SOI, 1'b1, 1'b0);
                    parse_phase = jmss_pkg::PH_HDR;
                end
                else
                    parse_phase = jmss_pkg::PH_FAIL;
            end
            jmss_pkg::PH_HDR:
            begin
                // a header byte that ends the file is dropped
                if (!eof)
                begin
                    if (b == jmss_pkg::MK_PREFIX)
                        parse_phase = jmss_pkg::PH_MARK;
                    else
                        push_out(b, 1'b1, 1'b0);
                end
            end
            jmss_pkg::PH_MARK:
            begin
                if (b == jmss_pkg::MK_EOI)
                begin
                    push_out(jmss_pkg::MK_PREFIX, 1'b1, 1'b0);
                    push_out(jmss_pkg::MK_EOI, 1'b1, 1'b1);
                    parse_phase = jmss_pkg::PH_DONE;
                end
                else if (b == jmss_pkg::MK_SOI ||
                         (b >= jmss_pkg::MK_RST0 && b <= jmss_pkg::MK_RST7) ||
                         b == jmss_pkg::MK_STUFF)
                begin
                    push_out(jmss_pkg::MK_PREFIX, 1'b1, 1'b0);
                    push_out(b, 1'b1, 1'b0);
                    parse_phase = jmss_pkg::PH_HDR;
                end
                else
                begin
                    seg_code    = b;
                    parse_phase = jmss_pkg::PH_LENHI;
                end
            end
            jmss_pkg::PH_LENHI:
            begin
                seg_len_hi  = b;
                parse_phase = jmss_pkg::PH_LENLO;
            end
            jmss_pkg::PH_LENLO:
            begin
                seg_len = {seg_len_hi, b};
                if (seg_len < 16'd2)
                    parse_phase = jmss_pkg::PH_HDR;
                else
                begin
                    seg_dropped    = (seg_code == jmss_pkg::MK_APP1) ||
                                     (seg_code == jmss_pkg::MK_APP2) ||
                                     (seg_code == jmss_pkg::MK_APP13);
                    scan_after_seg = !seg_dropped && (seg_code == jmss_pkg::MK_SOS);
                    if (!seg_dropped)
                    begin
                        push_out(jmss_pkg::MK_PREFIX, 1'b1, 1'b0);
                        push_out(seg_code, 1'b1, 1'b0);
                        push_out(seg_len_hi, 1'b1, 1'b0);
                        push_out(b, 1'b1, 1'b0);
                    end
                    seg_left = seg_len - 16'd2;
                    if (seg_left == 16'd0)
                        close_segment();
                    else
                        parse_phase = jmss_pkg::PH_PAYLOAD;
                end
            end
            jmss_pkg::PH_PAYLOAD:
            begin
                if (!seg_dropped)
                    push_out(b, 1'b1, 1'b0);
                seg_left = seg_left - 16'd1;
                if (seg_left == 16'd0)
                    close_segment();
            end
            jmss_pkg::PH_SCAN:
            begin
                if (scan_prev_ff && b == jmss_pkg::MK_EOI)
                begin
                    push_out(b, 1'b1, 1'b1);
                    parse_phase = jmss_pkg::PH_DONE;
                end
                else
                    push_out(b, 1'b1, 1'b0);
                scan_prev_ff = (b == jmss_pkg::MK_PREFIX);
            end
            jmss_pkg::PH_DONE: ;
            default: parse_phase = jmss_pkg::PH_FAIL;
        endcase

        // end of file: mark the last result or add an empty closing one
        if (eof)
        begin
            if (entry != jmss_pkg::PH_DONE)
            begin
                if (pending_out.size() > start)
                    pending_out[pending_out.size() - 1].last = 1'b1;
                else
                    push_out(8'h00, 1'b0, 1'b1);
            end
            reset_parser();
        end
    endtask

    //--------------------------------------------------------------------------
    // Monitor: predict on input transfers, check output transfers, watchdog
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_filtered(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (pending_out.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h byte_valid %0b last %0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_cnt++;
                end
                else
                begin
                    want_res = pending_out.pop_front();
                    if (m_tdata !== want_res.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want_res.data, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tuser !== want_res.valid)
                    begin
                        $error("byte_valid: expected %0b, actual %0b", want_res.valid, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tlast !== want_res.last)
                    begin
                        $error("last: expected %0b, actual %0b", want_res.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $error("no transfer for %0d cycles", quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Output ready: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_grants != hold_reqs)
        begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_grants <= hold_grants + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    //--------------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------------
    // One byte transfer, with random idle cycles in front
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Stop offering and wait for every predicted result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0)
            @(posedge clk);
    endtask

    // Append one byte to the file under construction
    function automatic void add_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endfunction

    task automatic push_random(input int cnt);
        repeat (cnt) add_byte(8'($urandom_range(255)));
    endtask

    // Append one header-phase item; open_ended marks a segment whose payload runs past EOF
    task automatic add_segment(output bit open_ended);
        int         kind;
        int         len;
        logic [7:0] code;
        open_ended = 1'b0;
        kind = $urandom_range(9);
        case (kind)
            0, 1:
            begin
                // stripped APP segment
                case ($urandom_range(2))
                    0:       code = jmss_pkg::MK_APP1;
                    1:       code = jmss_pkg::MK_APP2;
                    default: code = jmss_pkg::MK_APP13;
                endcase
                len = $urandom_range(2, 8);
                add_byte(jmss_pkg::MK_PREFIX);
                add_byte(code);
                add_byte(8'h00);
                add_byte(8'(len));
                push_random(len - 2);
            end
            2, 3, 4:
            begin
                // segment with a random code C0-FF and a length; RST0-EOI become DHT
                code = 8'($urandom_range(8'hFF, 8'hC0));
                if (code >= jmss_pkg::MK_RST0 && code <= jmss_pkg::MK_EOI)
                    code = MK_DHT;
                len = $urandom_range(2, 8);
                add_byte(jmss_pkg::MK_PREFIX);
                add_byte(code);
                add_byte(8'h00);
                add_byte(8'(len));
                push_random(len - 2);
            end
            5:
            begin
                // standalone marker
                add_byte(jmss_pkg::MK_PREFIX);
                case ($urandom_range(2))
                    0:       add_byte(jmss_pkg::MK_SOI);
                    1:       add_byte(8'($urandom_range(jmss_pkg::MK_RST7,
                                                        jmss_pkg::MK_RST0)));
                    default: add_byte(jmss_pkg::MK_STUFF);
                endcase
            end
            6:  add_byte(8'($urandom_range(8'hFE)));
            7:
            begin
                // length below two
                add_byte(jmss_pkg::MK_PREFIX);
                add_byte(8'($urandom_range(8'hFF, 8'hC0)));
                add_byte(8'h00);
                add_byte(8'($urandom_range(1)));
            end
            8:
            begin
                // random 16-bit length, payload cut short by end of file
                add_byte(jmss_pkg::MK_PREFIX);
                add_byte($urandom_range(1) ? MK_SOF0 : jmss_pkg::MK_APP1);
                add_byte(8'($urandom_range(255)));
                add_byte(8'($urandom_range(255)));
                push_random($urandom_range(6));
                open_ended = 1'b1;
            end
            default:
            begin
                add_byte(jmss_pkg::MK_PREFIX);
                add_byte(jmss_pkg::MK_STUFF);
            end
        endcase
    endtask

    // Kept SOS segment followed by entropy data and EOI
    task automatic add_scan();
        int len;
        len = $urandom_range(2, 5);
        add_byte(jmss_pkg::MK_PREFIX);
        add_byte(jmss_pkg::MK_SOS);
        add_byte(8'h00);
        add_byte(8'(len));
        push_random(len - 2);
        repeat ($urandom_range(12))
        begin
            if ($urandom_range(3) == 0)
                add_byte(jmss_pkg::MK_PREFIX);
            else
                add_byte(8'($urandom_range(255)));
        end
        add_byte(jmss_pkg::MK_PREFIX);
        add_byte(jmss_pkg::MK_EOI);
    endtask

    // Build one random file; useful counts the bytes the parser acts on
    task automatic build_random_file(output int useful);
        int pick;
        int cut;
        bit open_ended;
        file_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // noise, mostly a bad signature
            push_random($urandom_range(1, 8));
            useful = 1;
        end
        else if (pick < 12)
        begin
            // wrong second signature byte
            add_byte(jmss_pkg::MK_PREFIX);
            add_byte($urandom_range(1) ? jmss_pkg::MK_EOI : 8'($urandom_range(255)));
            push_random($urandom_range(3));
            useful = 1;
        end
        else
        begin
            add_byte(jmss_pkg::MK_PREFIX);
            add_byte(jmss_pkg::MK_SOI);
            open_ended = 1'b0;
            repeat ($urandom_range(4))
                if (!open_ended)
                    add_segment(open_ended);
            if (!open_ended)
            begin
                if ($urandom_range(2) != 0)
                    add_scan();
                else
                begin
                    add_byte(jmss_pkg::MK_PREFIX);
                    add_byte(jmss_pkg::MK_EOI);
                end
            end
            useful = file_bytes.size();
            // bytes after EOI
            if (!open_ended && $urandom_range(99) < 20)
                push_random($urandom_range(1, 3));
            // cut the file anywhere: truncated payloads, missing lengths
            if ($urandom_range(99) < 15)
            begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
                useful = cut;
            end
        end
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------
    task automatic test_bad_signature();
        file_bytes = '{8'h00};
        send_file();
        wait_drained();
    endtask

    // APP1 removed, RST passed, EOI in the header phase, byte after EOI ignored
    task automatic test_strip_and_eoi();
        file_bytes = '{jmss_pkg::MK_PREFIX, jmss_pkg::MK_SOI, jmss_pkg::MK_PREFIX,
                       jmss_pkg::MK_APP1, 8'h00, 8'h03, 8'hAA,
                       jmss_pkg::MK_PREFIX, jmss_pkg::MK_RST0, jmss_pkg::MK_PREFIX,
                       jmss_pkg::MK_EOI, 8'h77};
        send_file();
        wait_drained();
    endtask

    // FF FF marker with short length, then SOS and scan data ending in FF FF D9
    task automatic test_short_length_and_scan();
        file_bytes = '{jmss_pkg::MK_PREFIX, jmss_pkg::MK_SOI, jmss_pkg::MK_PREFIX,
                       jmss_pkg::MK_PREFIX, 8'h00, 8'h01,
                       jmss_pkg::MK_PREFIX, jmss_pkg::MK_SOS, 8'h00, 8'h02,
                       jmss_pkg::MK_PREFIX, jmss_pkg::MK_PREFIX, jmss_pkg::MK_EOI};
        send_file();
        wait_drained();
    endtask

    // File ends on a byte where a marker would start
    task automatic test_trailing_header_byte();
        file_bytes = '{jmss_pkg::MK_PREFIX, jmss_pkg::MK_SOI, jmss_pkg::MK_PREFIX};
        send_file();
        wait_drained();
    endtask

    task automatic test_random_files(input int idle_pct, input int stall_pct,
                                     input int budget);
        int sent;
        int useful;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget)
        begin
            build_random_file(useful);
            send_file();
            sent += useful;
        end
        wait_drained();
    endtask

    // Receiver holds off while kept segments keep coming, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_reqs++;
        file_bytes = '{jmss_pkg::MK_PREFIX, jmss_pkg::MK_SOI};
        repeat (6)
        begin
            add_byte(jmss_pkg::MK_PREFIX);
            add_byte(MK_SOF0);
            add_byte(8'h00);
            add_byte(8'd10);
            push_random(8);
        end
        add_byte(jmss_pkg::MK_PREFIX);
        add_byte(jmss_pkg::MK_EOI);
        send_file();
        wait_drained();
    endtask

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial
    begin
        reset_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_signature();
        test_strip_and_eoi();
        test_short_length_and_scan();
        test_trailing_header_byte();
        test_output_backpressure();
        test_random_files(0, 0, 90);
        test_random_files(71, 0, 90);
        test_random_files(0, 71, 90);
        test_random_files(36, 36, 90);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_out.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_out.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
